// ===== sv/arot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arot_pkg: shared definitions of the ac rms meter
// Field widths, register map, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package arot_pkg;

	// Parameter defaults.
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH     = 2;

	// Field widths on the ports.
	localparam int ADC_CODE_W  = 12;
	localparam int RMS_VOLTS_W = 24;
	localparam int NEW_ZERO_W  = 20;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 48;

	// Configuration registers.
	localparam int WINDOW_W   = 16;
	localparam int GAIN_W     = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1024;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'd65536;

	localparam logic [RMS_VOLTS_W-1:0] RMS_MAX = {RMS_VOLTS_W{1'b1}};

	typedef enum logic {
		REG_WINDOW = 1'b0,
		REG_GAIN   = 1'b1
	} reg_idx_t;

endpackage

// ===== sv/arot_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arot_queue: window summary queue
// A small register queue that carries closed window sums from the sample
// accumulator to the arithmetic sequencer.
// ----------------------------------------------------------------------------
module arot_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = arot_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");

endmodule

// ===== sv/arot_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arot_front: sample accumulator
// Squares each sample, sums samples and squares over a window and hands the
// closed window to the queue. The offset is applied later in the back end.
// ----------------------------------------------------------------------------
module arot_front #(
	parameter int SAMPLE_BITS = arot_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = arot_pkg::COUNT_BITS_DEF,
	localparam int SW = SAMPLE_BITS + COUNT_BITS,
	localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS,
	localparam int EW = QW + SW + COUNT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [arot_pkg::ADC_CODE_W-1:0] adc_code,
	input  logic [arot_pkg::WINDOW_W-1:0] window_samples,
	output logic                          push,
	output logic [EW-1:0]                 push_data,
	input  logic                          queue_full
);

	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 1);

	logic                      valid_s1;
	logic [SAMPLE_BITS-1:0]    code_s1;
	logic [2*SAMPLE_BITS-1:0]  square_s1;

	logic [COUNT_BITS-1:0] count_q;
	logic [SW-1:0]         sum_q;
	logic [QW-1:0]         sumsq_q;

	logic [SAMPLE_BITS-1:0] code;
	logic [COUNT_BITS-1:0]  win_eff;
	logic [COUNT_BITS-1:0]  count_n;
	logic [SW-1:0]          sum_n;
	logic [QW-1:0]          sumsq_n;
	logic                   close;
	logic                   advance;

	assign code = SAMPLE_BITS'(adc_code);

	// A zero window acts as one sample; a long window is cut at the counter range.
	always_comb begin
		if (window_samples == '0) begin
			win_eff = COUNT_BITS'(1);
		end else if (32'(window_samples) > COUNT_MAX) begin
			win_eff = COUNT_BITS'(COUNT_MAX);
		end else begin
			win_eff = COUNT_BITS'(window_samples);
		end
	end

	assign count_n = count_q + 1'b1;
	assign sum_n   = sum_q + SW'(code_s1);
	assign sumsq_n = sumsq_q + QW'(square_s1);
	assign close   = (count_n >= win_eff);
	assign advance = valid_s1 && (!close || !queue_full);
	assign in_ready = !valid_s1 || advance;

	assign push      = valid_s1 && close && !queue_full;
	assign push_data = {sumsq_n, sum_n, count_n};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1   <= code;
			square_s1 <= code * code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
			sum_q    <= '0;
			sumsq_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (close) begin
					count_q <= '0;
					sum_q   <= '0;
					sumsq_q <= '0;
				end else begin
					count_q <= count_n;
					sum_q   <= sum_n;
					sumsq_q <= sumsq_n;
				end
			end
		end
	end

endmodule

// ===== sv/arot_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arot_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by the mean and the
// mean square of each window.
// ----------------------------------------------------------------------------
module arot_div #(
	parameter int DW = 56,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [VW:0] rem_sh;
	logic        ge;
	logic [VW:0] rem_n;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge     = (rem_sh >= {1'b0, div_q});
	assign rem_n  = ge ? rem_sh - {1'b0, div_q} : rem_sh;

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so its top bit is clear.
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= rem_n[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/arot_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arot_back: window arithmetic sequencer
// Takes closed windows from the queue, applies the stored offset, divides,
// takes the square root, scales by the gain and loads the result register.
// ----------------------------------------------------------------------------
module arot_back #(
	parameter int SAMPLE_BITS = arot_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = arot_pkg::COUNT_BITS_DEF,
	localparam int SW = SAMPLE_BITS + COUNT_BITS,
	localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS,
	localparam int EW = QW + SW + COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              queue_empty,
	input  logic [EW-1:0]                     queue_data,
	output logic                              pop,
	input  logic [arot_pkg::GAIN_W-1:0]       output_gain,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [arot_pkg::RMS_VOLTS_W-1:0]  rms_volts,
	output logic [arot_pkg::NEW_ZERO_W-1:0]   new_zero
);

	localparam int ZW  = SAMPLE_BITS + 8;
	localparam int SQW = 2 * ZW + COUNT_BITS;
	localparam int PW  = ZW + arot_pkg::GAIN_W;
	localparam int CW  = $clog2(ZW + 1);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MEAN  = 10'b0000000010,
		ST_PROD  = 10'b0000000100,
		ST_TERM  = 10'b0000001000,
		ST_MULT  = 10'b0000010000,
		ST_SUM   = 10'b0000100000,
		ST_MSQ   = 10'b0001000000,
		ST_SQRT  = 10'b0010000000,
		ST_SCALE = 10'b0100000000,
		ST_ROUND = 10'b1000000000
	} state_t;

	state_t state_q;
	logic   calibrated_q;
	logic [ZW-1:0] z_q;

	logic [COUNT_BITS-1:0] n_q;
	logic [SW-1:0]         sum_q;
	logic [QW-1:0]         sumsq_q;
	logic [ZW-1:0]         mean_q;
	logic [COUNT_BITS+ZW-1:0] nz_q;

	logic [SQW-1:0] mcand_q;
	logic [ZW-1:0]  mplier_q;
	logic [SQW-1:0] acc_q;
	logic [CW-1:0]  cnt_q;

	logic [2*ZW-1:0] rad_q;
	logic [ZW+1:0]   rem_q;
	logic [ZW-1:0]   root_q;
	logic [PW-1:0]   prod_q;

	logic                            out_valid_q;
	logic [arot_pkg::RMS_VOLTS_W-1:0] rms_q;
	logic [arot_pkg::NEW_ZERO_W-1:0]  zero_q;

	logic [COUNT_BITS-1:0] in_n;
	logic [SW-1:0]         in_sum;
	logic [QW-1:0]         in_sumsq;

	logic            div_start;
	logic [SQW-1:0]  div_dividend;
	logic [COUNT_BITS-1:0] div_divisor;
	logic            div_done;
	logic [SQW-1:0]  div_quotient;

	logic [SQW-1:0] sqsum;
	logic [ZW+1:0]  rem_sh;
	logic [ZW+1:0]  trial;
	logic           fits;
	logic [PW-1:0]  rounded;
	logic [PW-17:0] volts_full;
	logic [arot_pkg::RMS_VOLTS_W-1:0] volts;
	logic           out_load;

	assign {in_sumsq, in_sum, in_n} = queue_data;

	assign pop = (state_q == ST_IDLE) && !queue_empty;

	// Sum of squared deviations: 2^16*Q - 2^9*z*S + n*z^2 = 2^16*Q + z*(n*z - 2^9*S).
	// The partial terms run modulo 2^SQW; the true value always fits.
	assign sqsum = (SQW'(sumsq_q) << 16) + acc_q;

	always_comb begin
		div_start   = 1'b0;
		div_dividend = sqsum;
		div_divisor = n_q;
		if (pop) begin
			div_start    = 1'b1;
			div_dividend = (SQW'(in_sum) << 8) + SQW'(in_n >> 1);
			div_divisor  = in_n;
		end else if (state_q == ST_SUM) begin
			div_start = 1'b1;
		end
	end

	arot_div #(
		.DW(SQW),
		.VW(COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Square root, two radicand bits per step.
	assign rem_sh = {rem_q[ZW-1:0], rad_q[2*ZW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	assign rounded    = prod_q + PW'(32768);
	assign volts_full = rounded[PW-1:16];
	assign volts      = (volts_full > (PW-16)'(arot_pkg::RMS_MAX)) ?
		arot_pkg::RMS_MAX : arot_pkg::RMS_VOLTS_W'(volts_full);

	assign out_load = (state_q == ST_ROUND) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign rms_volts = rms_q;
	assign new_zero  = zero_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			n_q     <= in_n;
			sum_q   <= in_sum;
			sumsq_q <= in_sumsq;
		end
		if (state_q == ST_MEAN && div_done) begin
			mean_q <= ZW'(div_quotient);
		end
		if (state_q == ST_PROD) begin
			nz_q <= n_q * z_q;
		end
		if (state_q == ST_TERM) begin
			mcand_q  <= SQW'(nz_q) - (SQW'(sum_q) << 9);
			mplier_q <= z_q;
			acc_q    <= '0;
		end
		if (state_q == ST_MULT) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (state_q == ST_MSQ && div_done) begin
			rad_q  <= (2*ZW)'(div_quotient);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == ST_SQRT) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ZW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ZW-2:0], 1'b0};
			end
		end
		if (state_q == ST_SCALE) begin
			prod_q <= root_q * output_gain;
		end
		if (out_load) begin
			rms_q  <= volts;
			zero_q <= arot_pkg::NEW_ZERO_W'(mean_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			calibrated_q <= 1'b0;
			z_q          <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						if (calibrated_q) begin
							state_q <= ST_PROD;
						end else begin
							// The first window only sets the offset.
							z_q          <= ZW'(div_quotient);
							calibrated_q <= 1'b1;
							state_q      <= ST_IDLE;
						end
					end
				end
				ST_PROD: begin
					state_q <= ST_TERM;
				end
				ST_TERM: begin
					cnt_q   <= CW'(ZW);
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_MSQ;
				end
				ST_MSQ: begin
					if (div_done) begin
						cnt_q   <= CW'(ZW);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_load) begin
						z_q     <= mean_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_MEAN || state_q == ST_MSQ))
		else $error("divider finished outside a wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> calibrated_q)
		else $error("result produced before calibration");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("result register overwritten while still held");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_MEAN))
		else $error("window taken without starting the mean");

endmodule

// ===== sv/ac_rms_with_offset_tracking_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_rms_with_offset_tracking_unit: true rms meter with offset tracking
// Cuts the sample stream into windows, removes the tracked zero offset and
// reports the scaled rms value and new offset for each window but the first.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer                        Content
// s_*       in         s_tvalid & s_tready             tdata[11:0] adc_code
// m_*       out        m_tvalid & m_tready             tdata[23:0] rms_volts,
//                                                      tdata[43:24] new_zero
// APB       in         psel & penable & pwrite         0x0 window_samples,
//                                                      0x4 output_gain
//
// Samples are taken at one per cycle unless the input stalls; the square is
// registered, then summed. The back end takes one closed window at a time
// through the shared bit-serial divider (mean), the serial offset multiply,
// the divider again (mean square) and the square root, with ZW set to
// SAMPLE_BITS + 8, SQW to 2*ZW + COUNT_BITS. Two closed windows can wait in
// the queue; when it is full the input stalls. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module ac_rms_with_offset_tracking_unit #(
	parameter int SAMPLE_BITS = arot_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = arot_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata fields from bit 0: adc_code[11:0], zero pad[15:12]
	input  logic [arot_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata fields from bit 0: rms_volts[23:0], new_zero[43:24], zero pad[47:44]
	output logic [arot_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [arot_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [arot_pkg::APB_DATA_W-1:0] pwdata,
	output logic [arot_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int SW = SAMPLE_BITS + COUNT_BITS;
	localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int EW = QW + SW + COUNT_BITS;

	logic [arot_pkg::WINDOW_W-1:0] window_q;
	logic [arot_pkg::GAIN_W-1:0]   gain_q;
	arot_pkg::reg_idx_t            reg_idx;
	logic                          cfg_write;

	logic          push;
	logic          pop;
	logic          queue_full;
	logic          queue_empty;
	logic [EW-1:0] push_data;
	logic [EW-1:0] queue_data;

	logic [arot_pkg::RMS_VOLTS_W-1:0] rms_volts;
	logic [arot_pkg::NEW_ZERO_W-1:0]  new_zero;

	assign pready    = 1'b1;
	assign reg_idx   = arot_pkg::reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= arot_pkg::WINDOW_RESET;
			gain_q   <= arot_pkg::GAIN_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				arot_pkg::REG_WINDOW: window_q <= pwdata[arot_pkg::WINDOW_W-1:0];
				arot_pkg::REG_GAIN:   gain_q   <= pwdata[arot_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			arot_pkg::REG_WINDOW: prdata = arot_pkg::APB_DATA_W'(window_q);
			arot_pkg::REG_GAIN:   prdata = arot_pkg::APB_DATA_W'(gain_q);
			default:              prdata = '0;
		endcase
	end

	arot_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.adc_code       (s_tdata[arot_pkg::ADC_CODE_W-1:0]),
		.window_samples (window_q),
		.push           (push),
		.push_data      (push_data),
		.queue_full     (queue_full)
	);

	arot_queue #(
		.WIDTH(EW),
		.DEPTH(arot_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (queue_full),
		.pop    (pop),
		.rdata  (queue_data),
		.empty  (queue_empty)
	);

	arot_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_data  (queue_data),
		.pop         (pop),
		.output_gain (gain_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.rms_volts   (rms_volts),
		.new_zero    (new_zero)
	);

	assign m_tdata = {4'b0000, new_zero, rms_volts};

endmodule
